### rtl/core/ptsl_pkg.sv
package ptsl_pkg;

  // default sizes of the table
  localparam int unsigned MAX_CHAMBERS_DEF = 32;
  localparam int unsigned MAX_STRIPS_DEF   = 32;
  localparam int unsigned COORD_BITS_DEF   = 18;

  // fixed field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CHAMBER_W   = 5;
  localparam int unsigned STRIP_W     = 5;
  localparam int unsigned COUNT_IN_W  = 6;
  localparam int unsigned STRIP_NUM_W = 6;
  localparam int unsigned TOL_W       = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_BOUNDS = 2'd0,
    CMD_SET_COUNT   = 2'd1,
    CMD_LOOKUP      = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### rtl/core/point_to_strip_lookup.sv
// point_to_strip_lookup
//
// keeps a strip rectangle table per chamber and answers point lookups.
// item channel (item_valid / item_stall): one beat carries a command.
//   load bounds and set count commands update the tables and give no result.
//   a lookup beat scans the chamber's strips from index 0 upward and gives
//   one result beat on the result channel (result_valid / result_stall):
//   found and the one-based strip_number of the first strip whose bounds,
//   widened by edge_tolerance, hold the point, else found 0 and number 0.
// config: edge_tolerance_we writes edge_tolerance_wdata into the tolerance.
// sequence: a lookup starts with a read setup step, then makes one compare per
//   strip through the single registered bounds read port and the one shared
//   compare unit, and ends in a done state that loads the result register.
//   a hit ends the scan early. the item side stalls until the cycle after
//   the result load, so a new item is taken only once the last lookup is
//   through; an empty chamber's lookup goes straight to the done state.
// result: held in an output register, so the next item is taken while a
//   result beat waits; a finished lookup waits in its last state while the
//   receiver stalls and an earlier result is still held.
// reset: clears strip counts to zero and the tolerance to 5 (0.05 cm).
//   strip bounds are not cleared; they are valid once loaded.
module point_to_strip_lookup
  import ptsl_pkg::*;
#(
  parameter int unsigned MAX_CHAMBERS = MAX_CHAMBERS_DEF,
  parameter int unsigned MAX_STRIPS   = MAX_STRIPS_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config
  input  logic                         edge_tolerance_we,
  input  logic [TOL_W-1:0]             edge_tolerance_wdata,
  // item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [CMD_W-1:0]             cmd,
  input  logic [CHAMBER_W-1:0]         chamber,
  input  logic [STRIP_W-1:0]           strip,
  input  logic [COUNT_IN_W-1:0]        strip_count,
  input  logic signed [COORD_BITS-1:0] x_low,
  input  logic signed [COORD_BITS-1:0] x_high,
  input  logic signed [COORD_BITS-1:0] y_low,
  input  logic signed [COORD_BITS-1:0] y_high,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         found,
  output logic [STRIP_NUM_W-1:0]       strip_number
);

  localparam int unsigned DEPTH  = MAX_CHAMBERS * MAX_STRIPS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CH_W   = (MAX_CHAMBERS > 1) ? $clog2(MAX_CHAMBERS) : 1;
  // strip count and scan index, able to hold MAX_STRIPS itself
  localparam int unsigned CNT_W  = $clog2(MAX_STRIPS + 1);
  // compare width, wide enough for a bound widened by the tolerance
  localparam int unsigned CMP_W  = COORD_BITS + 2;
  localparam int unsigned ENT_W  = 4 * COORD_BITS;
  // range checks run at this width
  localparam int unsigned RNG_W  = 8;

  // bounds memory: {x_low, x_high, y_low, y_high} per strip
  logic [ENT_W-1:0] bounds_mem [DEPTH];
  logic [ENT_W-1:0] rd_data;

  logic [CNT_W-1:0] count_table [MAX_CHAMBERS];
  logic [TOL_W-1:0] tolerance;

  state_t state, state_next;

  // lookup context
  logic signed [COORD_BITS-1:0] px, py;
  logic [ADDR_W-1:0]            base;
  logic [CNT_W-1:0]             cnt;
  logic [CNT_W-1:0]             iss;      // next strip to read
  logic [CNT_W-1:0]             chk;      // strip whose bounds sit in rd_data
  logic                         chk_vld;
  logic                         hit_found;
  logic [STRIP_NUM_W-1:0]       hit_num;

  // decode of the incoming beat
  logic             accept;
  logic             chamber_ok, strip_ok;
  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] count_rd;
  logic [ADDR_W-1:0] base_in;
  logic             rd_en;
  logic             match, last_chk, scan_end;
  logic             result_load;

  assign accept     = item_valid && !item_stall;
  assign chamber_ok = RNG_W'(chamber) < RNG_W'(MAX_CHAMBERS);
  assign strip_ok   = RNG_W'(strip) < RNG_W'(MAX_STRIPS);
  assign count_sat  = (RNG_W'(strip_count) > RNG_W'(MAX_STRIPS)) ?
                      CNT_W'(MAX_STRIPS) : CNT_W'(strip_count);
  assign count_rd   = chamber_ok ? count_table[CH_W'(chamber)] : '0;
  assign base_in    = ADDR_W'(chamber) * ADDR_W'(MAX_STRIPS);

  // shared compare unit: one strip's widened rectangle against the point
  logic signed [CMP_W-1:0] tol_s, pxw, pyw;
  logic signed [CMP_W-1:0] xl_w, xh_w, yl_w, yh_w;

  always_comb begin
    tol_s = signed'(CMP_W'(tolerance));
    pxw   = CMP_W'(px);
    pyw   = CMP_W'(py);
    xl_w  = CMP_W'(signed'(rd_data[4*COORD_BITS-1:3*COORD_BITS])) - tol_s;
    xh_w  = CMP_W'(signed'(rd_data[3*COORD_BITS-1:2*COORD_BITS])) + tol_s;
    yl_w  = CMP_W'(signed'(rd_data[2*COORD_BITS-1:COORD_BITS])) - tol_s;
    yh_w  = CMP_W'(signed'(rd_data[COORD_BITS-1:0])) + tol_s;
    match = (pxw >= xl_w) && (pxw <= xh_w) && (pyw >= yl_w) && (pyw <= yh_w);
  end

  assign rd_en    = (state == ST_SCAN) && (iss < cnt);
  assign last_chk = (chk + CNT_W'(1)) == cnt;
  assign scan_end = chk_vld && (match || last_chk);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd_t'(cmd) == CMD_LOOKUP) begin
          state_next = (count_rd == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall  = 1'b1;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: item_stall  = 1'b0;
      ST_SCAN: item_stall  = 1'b1;
      ST_DONE: result_load = !result_valid || !result_stall;
      default: item_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (edge_tolerance_we) begin
      tolerance <= edge_tolerance_wdata;
    end
  end

  // strip count table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHAMBERS; i++) begin
        count_table[i] <= '0;
      end
    end else if (accept && cmd_t'(cmd) == CMD_SET_COUNT && chamber_ok) begin
      count_table[CH_W'(chamber)] <= count_sat;
    end
  end

  // bounds memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(cmd) == CMD_LOAD_BOUNDS && chamber_ok && strip_ok) begin
      bounds_mem[base_in + ADDR_W'(strip)] <= {x_low, x_high, y_low, y_high};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= bounds_mem[base + ADDR_W'(iss)];
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld   <= 1'b0;
      iss       <= '0;
      chk       <= '0;
      cnt       <= '0;
      hit_found <= 1'b0;
    end else if (accept && cmd_t'(cmd) == CMD_LOOKUP) begin
      chk_vld   <= 1'b0;
      iss       <= '0;
      chk       <= '0;
      cnt       <= count_rd;
      hit_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      chk_vld <= rd_en && !scan_end;
      if (rd_en) begin
        iss <= iss + CNT_W'(1);
        chk <= iss;
      end
      if (chk_vld && match) begin
        hit_found <= 1'b1;
      end
    end
  end

  // lookup payload
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(cmd) == CMD_LOOKUP) begin
      px      <= point_x;
      py      <= point_y;
      base    <= base_in;
      hit_num <= '0;
    end else if (state == ST_SCAN && chk_vld && match) begin
      hit_num <= STRIP_NUM_W'(chk + CNT_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      found        <= hit_found;
      strip_number <= hit_num;
    end
  end

  // checks
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    result_load |-> (state == ST_DONE))
    else $error("result loaded outside the done state");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss <= cnt))
    else $error("scan read index past strip count");

  a_miss_has_no_number: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (strip_number == '0))
    else $error("strip number set without a hit");

  a_lookup_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_t'(cmd) == CMD_LOOKUP) |=> (state != ST_IDLE))
    else $error("lookup beat did not start the sequencer");

  a_check_follows_read: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> $past(rd_en))
    else $error("compare without a preceding memory read");

endmodule
